@@ src/etfi_pkg.sv @@
package etfi_pkg;

    localparam int FRAC_BITS        = 56;
    localparam int ESCAPE_RADIUS_SQ = 4;

    localparam int CFG_REGS   = 8;
    localparam int ADDR_WIDTH = 6;

    localparam logic [63:0] ONE_Q32      = 64'd1 << 32;
    localparam logic [63:0] X_START_RST  = 64'd0 - (64'd2 << FRAC_BITS);
    localparam logic [63:0] Y_START_RST  = 64'd0 - (64'd3 << (FRAC_BITS - 1));
    localparam logic [63:0] STEP_RST     = 64'd1 << (FRAC_BITS - 8);
    localparam logic [19:0] LIMIT_RST    = 20'd256;
    localparam logic [127:0] ESC_BOUND   = 128'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

    localparam logic [1:0] MODE_MANDEL  = 2'd0;
    localparam logic [1:0] MODE_FIXED_C = 2'd1;
    localparam logic [1:0] MODE_DIST    = 2'd2;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_X_START = 3'd1;
    localparam logic [2:0] REG_Y_START = 3'd2;
    localparam logic [2:0] REG_X_STEP  = 3'd3;
    localparam logic [2:0] REG_Y_STEP  = 3'd4;
    localparam logic [2:0] REG_JRE     = 3'd5;
    localparam logic [2:0] REG_JIM     = 3'd6;
    localparam logic [2:0] REG_LIMIT   = 3'd7;

    // Product codes: which operand pair goes to the multiplier.
    localparam int NUM_OPS = 9;
    localparam logic [3:0] OP_TX = 4'd0;
    localparam logic [3:0] OP_TY = 4'd1;
    localparam logic [3:0] OP_SR = 4'd2;
    localparam logic [3:0] OP_SI = 4'd3;
    localparam logic [3:0] OP_ZZ = 4'd4;
    localparam logic [3:0] OP_A  = 4'd5;
    localparam logic [3:0] OP_B  = 4'd6;
    localparam logic [3:0] OP_C  = 4'd7;
    localparam logic [3:0] OP_D  = 4'd8;

    localparam logic [2:0] MUL_PARTS = 3'd4;
    localparam logic [2:0] MUL_LAST  = 3'd5;

    typedef logic signed [127:0] t_w128;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] x_start;
        logic [63:0] y_start;
        logic [63:0] x_step;
        logic [63:0] y_step;
        logic [63:0] julia_re;
        logic [63:0] julia_im;
        logic [19:0] limit;
    } t_cfg;

    typedef struct packed {
        logic       in_load;
        logic       mul_start;
        logic [3:0] mul_op;
        logic       init;
        logic       update;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic esc;
        logic lim;
        logic dist_mode;
    } t_sts;

    function automatic t_w128 ext128(input logic [63:0] v);
        ext128 = {{64{v[63]}}, v};
    endfunction

    function automatic t_w128 sadd128(input t_w128 a, input t_w128 b);
        t_w128 s;
        s = a + b;
        if (a[127] == b[127] && s[127] != a[127]) begin
            s = a[127] ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
        end
        sadd128 = s;
    endfunction

    function automatic logic [63:0] sat64(input t_w128 a);
        if (&a[127:63] || ~|a[127:63]) begin
            sat64 = a[63:0];
        end else begin
            sat64 = a[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    endfunction

endpackage

@@ src/escape_time_fractal_iterator_unit.sv @@
// Escape-time fractal iterator (Mandelbrot, Julia, Mandelbrot with distance derivative).
// Input channel: i_valid / o_ready with i_pixel_x, i_pixel_y. A transaction is one pixel.
// Output channel: o_valid / i_ready with the echoed pixel, the iteration count, the final
// z and, in distance mode, the derivative (Q32.32); otherwise the derivative reads 0.
// Registers are written over the APB port at byte address 8*index, 64-bit data, pready
// always high; users must change them only while no pixel is in flight (not enforced).
// A single 32x32 multiplier builds every 64x64 product from four partial products, and
// it sets the pace: a pixel costs two products of setup, then three products per
// iteration, or seven per iteration in distance mode, and then a test of the limit and
// the load of the result.
// One pixel is worked on at a time; o_ready is high while the block is idle.
// The result sits in an output register, so a new pixel is taken while the previous
// result still waits. If the receiver stalls, the next finished pixel holds until the
// output register is free.
// A synchronous active-low reset returns all configuration registers to their defaults,
// clears the output valid flag and leaves the block idle.
module escape_time_fractal_iterator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_out_x,
    output logic [9:0]  o_out_y,
    output logic [19:0] o_iteration_count,
    output logic [63:0] o_last_re,
    output logic [63:0] o_last_im,
    output logic [63:0] o_deriv_re,
    output logic [63:0] o_deriv_im,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [etfi_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    etfi_pkg::t_cfg r_cfg;
    etfi_pkg::t_cmd w_cmd;
    etfi_pkg::t_sts w_sts;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx = paddr[etfi_pkg::ADDR_WIDTH-1:3];
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= etfi_pkg::MODE_MANDEL;
            r_cfg.x_start  <= etfi_pkg::X_START_RST;
            r_cfg.y_start  <= etfi_pkg::Y_START_RST;
            r_cfg.x_step   <= etfi_pkg::STEP_RST;
            r_cfg.y_step   <= etfi_pkg::STEP_RST;
            r_cfg.julia_re <= 64'd0;
            r_cfg.julia_im <= 64'd0;
            r_cfg.limit    <= etfi_pkg::LIMIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                etfi_pkg::REG_MODE:    r_cfg.mode     <= pwdata[1:0];
                etfi_pkg::REG_X_START: r_cfg.x_start  <= pwdata;
                etfi_pkg::REG_Y_START: r_cfg.y_start  <= pwdata;
                etfi_pkg::REG_X_STEP:  r_cfg.x_step   <= pwdata;
                etfi_pkg::REG_Y_STEP:  r_cfg.y_step   <= pwdata;
                etfi_pkg::REG_JRE:     r_cfg.julia_re <= pwdata;
                etfi_pkg::REG_JIM:     r_cfg.julia_im <= pwdata;
                default:               r_cfg.limit    <= pwdata[19:0];
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            etfi_pkg::REG_MODE:    prdata = {62'd0, r_cfg.mode};
            etfi_pkg::REG_X_START: prdata = r_cfg.x_start;
            etfi_pkg::REG_Y_START: prdata = r_cfg.y_start;
            etfi_pkg::REG_X_STEP:  prdata = r_cfg.x_step;
            etfi_pkg::REG_Y_STEP:  prdata = r_cfg.y_step;
            etfi_pkg::REG_JRE:     prdata = r_cfg.julia_re;
            etfi_pkg::REG_JIM:     prdata = r_cfg.julia_im;
            default:               prdata = {44'd0, r_cfg.limit};
        endcase
    end

    assign pready = 1'b1;

    etfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    etfi_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg             (r_cfg),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_iteration_count (o_iteration_count),
        .o_last_re         (o_last_re),
        .o_last_im         (o_last_im),
        .o_deriv_re        (o_deriv_re),
        .o_deriv_im        (o_deriv_im)
    );

endmodule

@@ src/etfi_mul.sv @@
module etfi_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output etfi_pkg::t_w128 o_p
);

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic        r_done;
    logic [63:0] r_ma;
    logic [63:0] r_mb;
    logic        r_neg;
    logic [63:0] r_pp;
    logic [1:0]  r_sh;
    logic [127:0] r_acc;
    etfi_pkg::t_w128 r_p;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [127:0] w_pp_sh;

    assign w_ah = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
    assign w_bh = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];

    always_comb begin
        case (r_sh)
            2'd0:    w_pp_sh = {64'd0, r_pp};
            2'd3:    w_pp_sh = {r_pp, 64'd0};
            default: w_pp_sh = {32'd0, r_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == etfi_pkg::MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Magnitude product from four 32x32 partial products, sign applied at the end.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? 64'd0 - i_a : i_a;
            r_mb  <= i_b[63] ? 64'd0 - i_b : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= 128'd0;
        end else if (r_busy) begin
            if (r_cnt < etfi_pkg::MUL_PARTS) begin
                r_pp <= {32'd0, w_ah} * {32'd0, w_bh};
                r_sh <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= etfi_pkg::MUL_PARTS) begin
                r_acc <= r_acc + w_pp_sh;
            end
            if (r_cnt == etfi_pkg::MUL_LAST) begin
                r_p <= r_neg ? 128'd0 - r_acc : r_acc;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

@@ src/etfi_dp.sv @@
module etfi_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  etfi_pkg::t_cmd   i_cmd,
    output etfi_pkg::t_sts   o_sts,
    input  etfi_pkg::t_cfg   i_cfg,
    input  logic [9:0]       i_pixel_x,
    input  logic [9:0]       i_pixel_y,
    output logic [9:0]       o_out_x,
    output logic [9:0]       o_out_y,
    output logic [19:0]      o_iteration_count,
    output logic [63:0]      o_last_re,
    output logic [63:0]      o_last_im,
    output logic [63:0]      o_deriv_re,
    output logic [63:0]      o_deriv_im
);

    logic [9:0]  r_px;
    logic [9:0]  r_py;
    logic [63:0] r_zr;
    logic [63:0] r_zi;
    logic [63:0] r_cr;
    logic [63:0] r_ci;
    logic [63:0] r_dr;
    logic [63:0] r_di;
    logic [19:0] r_count;
    etfi_pkg::t_w128 r_prod [etfi_pkg::NUM_OPS];

    logic [9:0]  r_ox;
    logic [9:0]  r_oy;
    logic [19:0] r_ocnt;
    logic [63:0] r_ore;
    logic [63:0] r_oim;
    logic [63:0] r_odr;
    logic [63:0] r_odi;

    logic [63:0] w_ma;
    logic [63:0] w_mb;
    logic        w_done;
    etfi_pkg::t_w128 w_p;
    logic        w_dist;
    logic        w_julia;
    logic [63:0] w_tx;
    logic [63:0] w_ty;
    logic [127:0] w_mag;
    etfi_pkg::t_w128 w_t;
    etfi_pkg::t_w128 w_u;
    etfi_pkg::t_w128 w_diff;
    logic [63:0] w_ndr;
    logic [63:0] w_ndi;
    logic [63:0] w_nzr;
    logic [63:0] w_nzi;

    assign w_dist  = (i_cfg.mode == etfi_pkg::MODE_DIST);
    assign w_julia = (i_cfg.mode == etfi_pkg::MODE_FIXED_C);

    always_comb begin
        case (i_cmd.mul_op)
            etfi_pkg::OP_TX: begin w_ma = i_cfg.x_step; w_mb = {54'd0, r_px}; end
            etfi_pkg::OP_TY: begin w_ma = i_cfg.y_step; w_mb = {54'd0, r_py}; end
            etfi_pkg::OP_SR: begin w_ma = r_zr; w_mb = r_zr; end
            etfi_pkg::OP_SI: begin w_ma = r_zi; w_mb = r_zi; end
            etfi_pkg::OP_ZZ: begin w_ma = r_zr; w_mb = r_zi; end
            etfi_pkg::OP_A:  begin w_ma = r_zr; w_mb = r_dr; end
            etfi_pkg::OP_B:  begin w_ma = r_zi; w_mb = r_di; end
            etfi_pkg::OP_C:  begin w_ma = r_zr; w_mb = r_di; end
            etfi_pkg::OP_D:  begin w_ma = r_zi; w_mb = r_dr; end
            default:         begin w_ma = r_zr; w_mb = r_zr; end
        endcase
    end

    etfi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_done),
        .o_p     (w_p)
    );

    assign w_tx = etfi_pkg::sat64(etfi_pkg::sadd128(r_prod[etfi_pkg::OP_TX],
                                                    etfi_pkg::ext128(i_cfg.x_start)));
    assign w_ty = etfi_pkg::sat64(etfi_pkg::sadd128(r_prod[etfi_pkg::OP_TY],
                                                    etfi_pkg::ext128(i_cfg.y_start)));

    // Both squares are non-negative, so the sum cannot wrap.
    assign w_mag = r_prod[etfi_pkg::OP_SR] + r_prod[etfi_pkg::OP_SI];

    assign w_t   = etfi_pkg::sadd128(r_prod[etfi_pkg::OP_A], 128'sd0 - r_prod[etfi_pkg::OP_B]);
    assign w_ndr = etfi_pkg::sat64(etfi_pkg::sadd128(w_t >>> (etfi_pkg::FRAC_BITS - 1),
                                                     etfi_pkg::ext128(etfi_pkg::ONE_Q32)));
    assign w_u   = etfi_pkg::sadd128(r_prod[etfi_pkg::OP_C], r_prod[etfi_pkg::OP_D]);
    assign w_ndi = etfi_pkg::sat64(w_u >>> (etfi_pkg::FRAC_BITS - 1));

    assign w_diff = etfi_pkg::sadd128(r_prod[etfi_pkg::OP_SR], 128'sd0 - r_prod[etfi_pkg::OP_SI]);
    assign w_nzr  = etfi_pkg::sat64(etfi_pkg::sadd128(w_diff >>> etfi_pkg::FRAC_BITS,
                                                      etfi_pkg::ext128(r_cr)));
    assign w_nzi  = etfi_pkg::sat64(etfi_pkg::sadd128(
                        r_prod[etfi_pkg::OP_ZZ] >>> (etfi_pkg::FRAC_BITS - 1),
                        etfi_pkg::ext128(r_ci)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (w_done) begin
            r_prod[i_cmd.mul_op] <= w_p;
        end
        if (i_cmd.init) begin
            r_zr    <= w_tx;
            r_zi    <= w_ty;
            r_cr    <= w_julia ? i_cfg.julia_re : w_tx;
            r_ci    <= w_julia ? i_cfg.julia_im : w_ty;
            r_dr    <= etfi_pkg::ONE_Q32;
            r_di    <= 64'd0;
            r_count <= 20'd0;
        end
        if (i_cmd.update) begin
            r_zr <= w_nzr;
            r_zi <= w_nzi;
            if (w_dist) begin
                r_dr <= w_ndr;
                r_di <= w_ndi;
            end
            // Landing exactly on the origin is treated as trapped.
            if (w_nzr == 64'd0 && w_nzi == 64'd0) begin
                r_count <= i_cfg.limit;
            end else begin
                r_count <= r_count + 20'd1;
            end
        end
        if (i_cmd.out_load) begin
            r_ox   <= r_px;
            r_oy   <= r_py;
            r_ocnt <= r_count;
            r_ore  <= r_zr;
            r_oim  <= r_zi;
            r_odr  <= w_dist ? r_dr : 64'd0;
            r_odi  <= w_dist ? r_di : 64'd0;
        end
    end

    assign o_sts.mul_done  = w_done;
    assign o_sts.esc       = (w_mag >= etfi_pkg::ESC_BOUND);
    assign o_sts.lim       = (r_count >= i_cfg.limit);
    assign o_sts.dist_mode = w_dist;

    assign o_out_x           = r_ox;
    assign o_out_y           = r_oy;
    assign o_iteration_count = r_ocnt;
    assign o_last_re         = r_ore;
    assign o_last_im         = r_oim;
    assign o_deriv_re        = r_odr;
    assign o_deriv_im        = r_odi;

endmodule

@@ src/etfi_ctrl.sv @@
module etfi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  etfi_pkg::t_sts i_sts,
    output etfi_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_LOOP  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [3:0] r_op;
    logic [3:0] n_op;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_cmd         = '0;
        o_cmd.mul_op  = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_op          = etfi_pkg::OP_TX;
                    n_state       = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = S_ISSUE;
                    case (r_op)
                        etfi_pkg::OP_TX: n_op = etfi_pkg::OP_TY;
                        etfi_pkg::OP_TY: n_state = S_INIT;
                        etfi_pkg::OP_SR: n_op = etfi_pkg::OP_SI;
                        etfi_pkg::OP_SI: n_state = S_CHECK;
                        etfi_pkg::OP_ZZ: begin
                            if (i_sts.dist_mode) begin
                                n_op = etfi_pkg::OP_A;
                            end else begin
                                n_state = S_UPD;
                            end
                        end
                        etfi_pkg::OP_A: n_op = etfi_pkg::OP_B;
                        etfi_pkg::OP_B: n_op = etfi_pkg::OP_C;
                        etfi_pkg::OP_C: n_op = etfi_pkg::OP_D;
                        default:        n_state = S_UPD;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_LOOP;
            end
            S_LOOP: begin
                if (i_sts.lim) begin
                    n_state = S_FIN;
                end else begin
                    n_op    = etfi_pkg::OP_SR;
                    n_state = S_ISSUE;
                end
            end
            S_CHECK: begin
                if (i_sts.esc) begin
                    n_state = S_FIN;
                end else begin
                    n_op    = etfi_pkg::OP_ZZ;
                    n_state = S_ISSUE;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_LOOP;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= etfi_pkg::OP_TX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ src/etfi_checker.sv @@
module etfi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [19:0] o_iteration_count,
    input logic [63:0] o_last_re,
    input logic        pready
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_iteration_count) && $stable(o_last_re))
        else $error("result payload changed while stalled");

    // Once a pixel is taken, the block is busy in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second pixel taken while one is in flight");

    // No result can appear in the cycle right after a pixel is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result appeared too early");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind escape_time_fractal_iterator_unit etfi_checker u_etfi_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_iteration_count (o_iteration_count),
    .o_last_re         (o_last_re),
    .pready            (pready)
);

@@ tb/tb_escape_time_fractal_iterator_unit.sv @@
`timescale 1ns / 1ps

module tb_escape_time_fractal_iterator_unit;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [9:0]  px;
        logic [9:0]  py;
    } t_pixel;

    typedef struct packed {
        logic [9:0]  px;
        logic [9:0]  py;
        logic [19:0] count;
        logic [63:0] zr;
        logic [63:0] zi;
        logic [63:0] dr;
        logic [63:0] di;
    } t_escape;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [9:0]  i_pixel_x;
    logic [9:0]  i_pixel_y;
    logic        o_valid;
    logic        i_ready;
    logic [9:0]  o_out_x;
    logic [9:0]  o_out_y;
    logic [19:0] o_iteration_count;
    logic [63:0] o_last_re;
    logic [63:0] o_last_im;
    logic [63:0] o_deriv_re;
    logic [63:0] o_deriv_im;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [etfi_pkg::ADDR_WIDTH-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    escape_time_fractal_iterator_unit dut (.*);

    etfi_pkg::t_cfg cfg;
    t_pixel   pixel_q[$];
    t_escape  escape_q[$];
    bit       started;
    bit       quiet;
    bit       pixel_taken;
    int       send_gap;
    int       recv_gap;
    int       errors;
    int       stuck_cycles;

    localparam int STUCK_LIMIT = 100000;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_wide widen(input logic [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    function automatic t_wide mul_exact(input logic [63:0] a, input logic [63:0] b);
        return widen(a) * widen(b);
    endfunction

    function automatic t_wide add_sat(input t_wide a, input t_wide b);
        t_wide s;
        s = a + b;
        if (a[127] == b[127] && s[127] != a[127])
            s = a[127] ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
        return s;
    endfunction

    function automatic logic [63:0] clamp64(input t_wide a);
        if (&a[127:63] || ~|a[127:63])
            return a[63:0];
        return a[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic [63:0] pixel_coord(input logic [63:0] start, input logic [63:0] step,
                                                 input logic [9:0] idx);
        return clamp64(add_sat(mul_exact(step, {54'd0, idx}), widen(start)));
    endfunction

    function automatic t_escape iterate_pixel(input t_pixel p);
        t_escape r;
        logic [63:0] tx, ty, cr, ci, zr, zi, dr, di, ndr, nzr, nzi;
        logic [127:0] mag;
        t_wide sr, si, t, u;
        bit julia, dist_on;
        int unsigned count;
        tx = pixel_coord(cfg.x_start, cfg.x_step, p.px);
        ty = pixel_coord(cfg.y_start, cfg.y_step, p.py);
        julia = (cfg.mode == etfi_pkg::MODE_FIXED_C);
        dist_on = (cfg.mode == etfi_pkg::MODE_DIST);
        cr = julia ? cfg.julia_re : tx;
        ci = julia ? cfg.julia_im : ty;
        zr = tx;
        zi = ty;
        dr = etfi_pkg::ONE_Q32;
        di = 64'd0;
        count = 0;
        while (count < cfg.limit) begin
            sr = mul_exact(zr, zr);
            si = mul_exact(zi, zi);
            // Both squares are nonnegative, so the sum is taken as unsigned.
            mag = sr + si;
            if (mag >= etfi_pkg::ESC_BOUND)
                break;
            if (dist_on) begin
                t = add_sat(mul_exact(zr, dr), -mul_exact(zi, di));
                ndr = clamp64(add_sat(t >>> (etfi_pkg::FRAC_BITS - 1),
                                      widen(etfi_pkg::ONE_Q32)));
                u = add_sat(mul_exact(zr, di), mul_exact(zi, dr));
                di = clamp64(u >>> (etfi_pkg::FRAC_BITS - 1));
                dr = ndr;
            end
            nzr = clamp64(add_sat(add_sat(sr, -si) >>> etfi_pkg::FRAC_BITS, widen(cr)));
            nzi = clamp64(add_sat(mul_exact(zr, zi) >>> (etfi_pkg::FRAC_BITS - 1), widen(ci)));
            zr = nzr;
            zi = nzi;
            if (zr == 64'd0 && zi == 64'd0) begin
                count = cfg.limit;
                break;
            end
            count++;
        end
        r.px = p.px;
        r.py = p.py;
        r.count = count[19:0];
        r.zr = zr;
        r.zi = zi;
        r.dr = dist_on ? dr : 64'd0;
        r.di = dist_on ? di : 64'd0;
        return r;
    endfunction

    // Input side: a transaction stays on the bus until it is taken.
    always @(negedge i_clk) begin
        if (started && (!i_valid || pixel_taken)) begin
            pixel_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                t_pixel p;
                p = pixel_q.pop_front();
                i_pixel_x <= p.px;
                i_pixel_y <= p.py;
                i_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 18);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (started) begin
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge i_clk) begin
        if (started) begin
            stuck_cycles++;
            if (i_valid && o_ready) begin
                t_pixel p;
                p.px = i_pixel_x;
                p.py = i_pixel_y;
                escape_q.push_back(iterate_pixel(p));
                pixel_taken = 1'b1;
                stuck_cycles = 0;
            end
            if (o_valid && i_ready) begin
                stuck_cycles = 0;
                if (escape_q.size() == 0) begin
                    $error("result with no pixel pending: x=%0d y=%0d", o_out_x, o_out_y);
                    errors++;
                end else begin
                    t_escape e;
                    e = escape_q.pop_front();
                    if (o_out_x !== e.px) begin
                        $error("out_x: expected %0d, got %0d", e.px, o_out_x);
                        errors++;
                    end
                    if (o_out_y !== e.py) begin
                        $error("out_y: expected %0d, got %0d", e.py, o_out_y);
                        errors++;
                    end
                    if (o_iteration_count !== e.count) begin
                        $error("iteration_count: expected %0d, got %0d", e.count,
                               o_iteration_count);
                        errors++;
                    end
                    if (o_last_re !== e.zr) begin
                        $error("last_re: expected %h, got %h", e.zr, o_last_re);
                        errors++;
                    end
                    if (o_last_im !== e.zi) begin
                        $error("last_im: expected %h, got %h", e.zi, o_last_im);
                        errors++;
                    end
                    if (o_deriv_re !== e.dr) begin
                        $error("deriv_re: expected %h, got %h", e.dr, o_deriv_re);
                        errors++;
                    end
                    if (o_deriv_im !== e.di) begin
                        $error("deriv_im: expected %h, got %h", e.di, o_deriv_im);
                        errors++;
                    end
                end
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb_escape_time_fractal_iterator_unit NOT OK");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            etfi_pkg::REG_MODE:    cfg.mode = val[1:0];
            etfi_pkg::REG_X_START: cfg.x_start = val;
            etfi_pkg::REG_Y_START: cfg.y_start = val;
            etfi_pkg::REG_X_STEP:  cfg.x_step = val;
            etfi_pkg::REG_Y_STEP:  cfg.y_step = val;
            etfi_pkg::REG_JRE:     cfg.julia_re = val;
            etfi_pkg::REG_JIM:     cfg.julia_im = val;
            etfi_pkg::REG_LIMIT:   cfg.limit = val[19:0];
            default: ;
        endcase
    endtask

    task automatic load_all(input logic [63:0] mode, input logic [63:0] xs,
                            input logic [63:0] ys, input logic [63:0] xd, input logic [63:0] yd,
                            input logic [63:0] jr, input logic [63:0] ji,
                            input logic [63:0] lim);
        reg_write(etfi_pkg::REG_MODE, mode);
        reg_write(etfi_pkg::REG_X_START, xs);
        reg_write(etfi_pkg::REG_Y_START, ys);
        reg_write(etfi_pkg::REG_X_STEP, xd);
        reg_write(etfi_pkg::REG_Y_STEP, yd);
        reg_write(etfi_pkg::REG_JRE, jr);
        reg_write(etfi_pkg::REG_JIM, ji);
        reg_write(etfi_pkg::REG_LIMIT, lim);
    endtask

    task automatic add_pixel(input int x, input int y);
        t_pixel p;
        p.px = x[9:0];
        p.py = y[9:0];
        pixel_q.push_back(p);
    endtask

    task automatic drain;
        while (pixel_q.size() > 0 || i_valid || escape_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Signed Q8.56 value in [-2, 2).
    function automatic logic [63:0] rand_point;
        logic [63:0] r;
        r = {$urandom, $urandom};
        return {{6{r[57]}}, r[57:0]};
    endfunction

    function automatic logic [63:0] rand_step;
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            return r;
        return $signed(rand_point()) >>> $urandom_range(10, 20);
    endfunction

    initial begin
        logic [63:0] xs, xd;
        started = 1'b0;
        quiet = 1'b0;
        pixel_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        errors = 0;
        stuck_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg.mode = etfi_pkg::MODE_MANDEL;
        cfg.x_start = etfi_pkg::X_START_RST;
        cfg.y_start = etfi_pkg::Y_START_RST;
        cfg.x_step = etfi_pkg::STEP_RST;
        cfg.y_step = etfi_pkg::STEP_RST;
        cfg.julia_re = 64'd0;
        cfg.julia_im = 64'd0;
        cfg.limit = etfi_pkg::LIMIT_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        started = 1'b1;

        // Defaults after reset: corners, the origin and the c = -1 cycle.
        add_pixel(0, 0);
        add_pixel(1023, 1023);
        add_pixel(0, 1023);
        add_pixel(1023, 0);
        add_pixel(512, 384);
        add_pixel(256, 384);
        add_pixel(700, 500);
        drain();

        // z starting at zero is trapped at once, even with the largest limit.
        load_all(etfi_pkg::MODE_MANDEL, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'hFFFFF);
        add_pixel(5, 7);
        drain();
        // c = -1 lands on zero after one step.
        reg_write(etfi_pkg::REG_X_START, -(64'd1 << etfi_pkg::FRAC_BITS));
        add_pixel(1023, 1023);
        drain();
        reg_write(etfi_pkg::REG_MODE, etfi_pkg::MODE_DIST);
        add_pixel(3, 9);
        drain();
        reg_write(etfi_pkg::REG_MODE, 64'd3);
        add_pixel(100, 200);
        drain();
        // Zero limit: z is the start point, derivative one.
        load_all(etfi_pkg::MODE_DIST, rand_point(), rand_point(), rand_step(), rand_step(),
                 64'd0, 64'd0, 64'd0);
        add_pixel(0, 1023);
        add_pixel(1023, 0);
        drain();
        // Julia with c = 0 from the origin traps; saturating extremes escape at once.
        load_all(etfi_pkg::MODE_FIXED_C, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd5);
        add_pixel(0, 0);
        drain();
        load_all(etfi_pkg::MODE_DIST, {1'b0, {63{1'b1}}}, {1'b1, 63'd0}, {1'b0, {63{1'b1}}},
                 {1'b1, 63'd0}, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 64'hFFFFF);
        add_pixel(1023, 1023);
        add_pixel(0, 0);
        drain();
        reg_write(etfi_pkg::REG_MODE, etfi_pkg::MODE_FIXED_C);
        add_pixel(1023, 1);
        drain();

        for (int ph = 0; ph < 17; ph++) begin
            if (ph >= 14)
                quiet = 1'b1;
            if (ph % 5 == 4) begin
                // Largest limit with every point well outside, so each pixel escapes.
                xs = (64'd3 << etfi_pkg::FRAC_BITS) + ($signed(rand_point()) >>> 4);
                xd = {$urandom, $urandom} >> 52;
                load_all(64'($urandom_range(0, 3)), xs, rand_point(), xd, rand_step(),
                         rand_point(), rand_point(), 64'hFFFFF);
            end else begin
                load_all({$urandom, $urandom}, rand_point(), rand_point(), rand_step(),
                         rand_step(), rand_point(), rand_point(),
                         64'($urandom_range(0, 24)));
            end
            for (int k = 0; k < 100; k++)
                add_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && escape_q.size() == 0)
            $display("tb_escape_time_fractal_iterator_unit OK");
        else
            $display("tb_escape_time_fractal_iterator_unit NOT OK");
        $finish;
    end
endmodule

@@ escape_time_fractal_iterator_unit.f @@
src/etfi_pkg.sv
src/etfi_mul.sv
src/etfi_dp.sv
src/etfi_ctrl.sv
src/escape_time_fractal_iterator_unit.sv
src/etfi_checker.sv
tb/tb_escape_time_fractal_iterator_unit.sv
